### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define SCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define SCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/scc_pkg.sv
// shared constants and codes for the strong connectivity checker
`timescale 1ns / 1ps
package scc_pkg;
	localparam int MAX_NODES_DEF = 256;
	localparam int NODE_W        = 9;
	localparam int ACT_W         = 2;

	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CHECK = 2'd2;
endpackage

### src/scc_bitmat.sv
// adjacency bit matrix memory: row clear or single bit set, one registered read
`timescale 1ns / 1ps
module scc_bitmat import scc_pkg::*; #(
	parameter int DEPTH = MAX_NODES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     clr,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [$clog2(DEPTH)-1:0] wbit,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DEPTH-1:0]         rdata
);
	logic [DEPTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			if (clr) begin
				mem[waddr] <= '0;
			end else begin
				mem[waddr][wbit] <= 1'b1;
			end
		end
		rdata <= mem[raddr];
	end
endmodule

### src/strong_connectivity_check_unit.sv
// top level: graph loader and strong connectivity walker
`timescale 1ns / 1ps
// clear word: clears every row of both matrices, input stalled meanwhile
// edge word: a two-way edge adds ST_EDGE2 (one bit write per matrix per cycle)
// check word: walk rescans the active rows, one matrix row read per cycle, forward then
//   reverse only if the forward walk reached every active node; result registered
// reset: asynchronous, active low; a clearing pass over all rows follows reset
module strong_connectivity_check_unit import scc_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [NODE_W-1:0] node_count,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	input  logic              two_way,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              strongly_connected,
	output logic              all_reached_forward
);
	localparam int NW   = $clog2(MAX_NODES);
	localparam int CW   = $clog2(MAX_NODES + 1);
	localparam int CMPW = (CW > NODE_W) ? CW : NODE_W;

	typedef enum logic [4:0] {
		ST_SWEEP = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_EDGE2 = 5'b00100,
		ST_WALK  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [NW-1:0]       sweep_q;     // row being cleared
	logic [CW-1:0]       active_q;    // node count of the graph
	logic [MAX_NODES-1:0] mask_q;     // one bit per active node
	logic [NW-1:0]       src_q, dst_q;  // held endpoints for the reverse half of a two-way edge
	logic [MAX_NODES-1:0] reached_q;
	logic [MAX_NODES-1:0] pending_q;  // reached but neighbors not yet expanded
	logic [NW-1:0]       scan_q;      // row address issued this cycle
	logic [NW-1:0]       scan_s1;     // row whose data is back
	logic                vld_s1;
	logic                phase_q;     // 0 forward walk, 1 reverse walk
	logic                fwd_q, both_q;
	logic                out_valid_q, sc_q, arf_q;
	logic                out_load;    // result register takes a new word

	// matrix ports
	logic                f_we, f_clr, r_we, r_clr;
	logic [NW-1:0]       f_addr, f_bit, r_addr, r_bit;
	logic [MAX_NODES-1:0] f_row, r_row;

	// input decode
	logic                accept;
	logic [CMPW-1:0]     nc_x, from_x, to_x, act_x;
	logic [CW-1:0]       active_d;
	logic [MAX_NODES-1:0] mask_d;
	logic                edge_ok;
	logic [NW-1:0]       src_d, dst_d;

	// walk datapath
	logic [MAX_NODES-1:0] row, nb, reach_n, pend_n;
	logic                take, all_reached;
	logic [NW-1:0]       last_idx;

	assign in_ready            = (state_q == ST_IDLE);
	assign accept              = in_valid && in_ready;
	assign out_valid           = out_valid_q;
	assign strongly_connected  = sc_q;
	assign all_reached_forward = arf_q;
	assign out_load            = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// clamp node count to 1..MAX_NODES and build the active mask
	always_comb begin
		nc_x = CMPW'(node_count);
		if (nc_x == '0) begin
			active_d = CW'(1);
		end else if (nc_x > CMPW'(MAX_NODES)) begin
			active_d = CW'(MAX_NODES);
		end else begin
			active_d = CW'(nc_x);
		end
		for (int i = 0; i < MAX_NODES; i++) begin
			mask_d[i] = (CW'(i) < active_d);
		end
	end

	// endpoints must lie in 1..active
	always_comb begin
		from_x  = CMPW'(from_node);
		to_x    = CMPW'(to_node);
		act_x   = CMPW'(active_q);
		edge_ok = (from_x != '0) && (from_x <= act_x) && (to_x != '0) && (to_x <= act_x);
		src_d   = NW'(from_x - CMPW'(1));
		dst_d   = NW'(to_x - CMPW'(1));
	end

	// matrix write port steering
	always_comb begin
		f_we   = 1'b0;
		f_clr  = 1'b0;
		f_addr = src_d;
		f_bit  = dst_d;
		r_we   = 1'b0;
		r_clr  = 1'b0;
		r_addr = dst_d;
		r_bit  = src_d;
		unique case (state_q)
			ST_SWEEP: begin
				f_we   = 1'b1;
				f_clr  = 1'b1;
				f_addr = sweep_q;
				r_we   = 1'b1;
				r_clr  = 1'b1;
				r_addr = sweep_q;
			end
			ST_IDLE: begin
				// first half of an edge: forward s->d, reverse d->s
				f_we = accept && (action == ACT_EDGE) && edge_ok;
				r_we = f_we;
			end
			ST_EDGE2: begin
				// second half of a two-way edge: forward d->s, reverse s->d
				f_we   = 1'b1;
				f_addr = dst_q;
				f_bit  = src_q;
				r_we   = 1'b1;
				r_addr = src_q;
				r_bit  = dst_q;
			end
			ST_WALK, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	scc_bitmat #(.DEPTH(MAX_NODES)) u_fwd (
		.clk   (clk),
		.we    (f_we),
		.clr   (f_clr),
		.waddr (f_addr),
		.wbit  (f_bit),
		.raddr (scan_q),
		.rdata (f_row)
	);

	scc_bitmat #(.DEPTH(MAX_NODES)) u_rev (
		.clk   (clk),
		.we    (r_we),
		.clr   (r_clr),
		.waddr (r_addr),
		.wbit  (r_bit),
		.raddr (scan_q),
		.rdata (r_row)
	);

	// expand one row: rows of pending nodes add their unreached neighbors
	always_comb begin
		row         = phase_q ? r_row : f_row;
		take        = vld_s1 && pending_q[scan_s1];
		nb          = take ? (row & mask_q & ~reached_q) : '0;
		reach_n     = reached_q | nb;
		pend_n      = (pending_q | nb) &
			~(take ? (MAX_NODES'(1) << scan_s1) : '0);
		all_reached = &(reach_n | ~mask_q);
		last_idx    = NW'(active_q - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			active_q    <= CW'(1);
			mask_q      <= MAX_NODES'(1);
			reached_q   <= '0;
			pending_q   <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			phase_q     <= 1'b0;
			fwd_q       <= 1'b0;
			both_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result word: load a new one or drop the one taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + NW'(1);
					if (sweep_q == NW'(MAX_NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (action)
							ACT_CLEAR: begin
								active_q <= active_d;
								mask_q   <= mask_d;
								sweep_q  <= '0;
								state_q  <= ST_SWEEP;
							end
							ACT_EDGE: begin
								if (edge_ok && two_way) begin
									state_q <= ST_EDGE2;
								end
							end
							ACT_CHECK: begin
								reached_q <= MAX_NODES'(1);
								pending_q <= MAX_NODES'(1);
								scan_q    <= '0;
								vld_s1    <= 1'b0;
								phase_q   <= 1'b0;
								state_q   <= ST_WALK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_EDGE2: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if ((pend_n == '0) && !phase_q && all_reached) begin
						// restart from node 1 on the reverse matrix
						fwd_q     <= 1'b1;
						reached_q <= MAX_NODES'(1);
						pending_q <= MAX_NODES'(1);
						scan_q    <= '0;
						vld_s1    <= 1'b0;
						phase_q   <= 1'b1;
					end else begin
						reached_q <= reach_n;
						pending_q <= pend_n;
						scan_q    <= (scan_q == last_idx) ? '0 : scan_q + NW'(1);
						vld_s1    <= 1'b1;
						if (pend_n == '0) begin
							if (!phase_q) begin
								fwd_q   <= all_reached;
								both_q  <= 1'b0;
								state_q <= ST_DONE;
							end else begin
								both_q  <= all_reached;
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		scan_s1 <= scan_q;
		if (accept) begin
			src_q <= src_d;
			dst_q <= dst_d;
		end
		if (out_load) begin
			sc_q  <= both_q;
			arf_q <= fwd_q;
		end
	end
endmodule

### src/scc_checker.sv
// port-level checks for the strong connectivity checker, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scc_checker import scc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [ACT_W-1:0] action,
	input logic             out_valid,
	input logic             out_ready,
	input logic             strongly_connected,
	input logic             all_reached_forward
);
	`SCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`SCC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(strongly_connected) && $stable(all_reached_forward), "result word changed while stalled")
	`SCC_ASSERT_IMP(a_sc_implies_fwd, out_valid, !strongly_connected || all_reached_forward, "strongly connected without forward reach")
	`SCC_ASSERT_NXT(a_check_busy, in_valid && in_ready && (action == ACT_CHECK), !in_ready, "check word did not start a walk")
	`SCC_ASSERT_NXT(a_clear_busy, in_valid && in_ready && (action == ACT_CLEAR), !in_ready, "clear word did not start a sweep")
endmodule

bind strong_connectivity_check_unit scc_checker u_scc_checker (.*);
